@@ hw/rtl/pkst_pkg.sv @@
// Shared types and constants of the pressed-key set tracker.
// Used by pkst_out_reg and pressed_key_set_tracker; no dependencies.
`default_nettype none

package pkst_pkg;

   localparam int DEF_SLOTS   = 64;
   localparam int DEF_WINDOWS = 8;

   localparam int ID_W        = 32;
   localparam int KEY_W       = 8;
   localparam int OP_W        = 2;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 16;
   localparam int RSP_PAD_W   = RSP_TDATA_W - KEY_W - 4;

   typedef enum logic [OP_W-1:0] {
      OP_PRESS   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_QUERY   = 2'd2,
      OP_FOCUS   = 2'd3
   } op_type;

   typedef struct packed {
      logic             no_window_room;
      logic             dropped;
      logic             last;
      logic             released_valid;
      logic [KEY_W-1:0] released_key;
      logic             key_held;
   } rsp_type;

endpackage

`default_nettype wire

@@ hw/rtl/pkst_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; no package dependencies.
`default_nettype none

module pkst_ram #(
   parameter int  WIDTH  = 8,
   parameter int  DEPTH  = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold read data while no read is issued
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/pkst_out_reg.sv @@
// Result output register of the pressed-key set tracker: holds one result
// transaction until the receiver takes it. Depends on pkst_pkg.
`default_nettype none

module pkst_out_reg (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                load,
   input  wire pkst_pkg::rsp_type                   data,
   output logic                                     free,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // key_held[0], released_key[8:1], released_valid[9], dropped[10],
   // no_window_room[11], zero[15:12]
   output logic      [pkst_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                                     rsp_tlast
);

   logic              valid_ff;
   logic              valid_in;
   pkst_pkg::rsp_type data_ff;

   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data;
      end
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = data_ff.last;
   assign rsp_tdata  = {{pkst_pkg::RSP_PAD_W{1'b0}}, data_ff.no_window_room, data_ff.dropped,
                        data_ff.released_valid, data_ff.released_key, data_ff.key_held};

endmodule

`default_nettype wire

@@ hw/rtl/pressed_key_set_tracker.sv @@
// Pressed-key set tracker: per-window held-key sets kept in two RAMs.
// Depends on pkst_pkg, pkst_ram and pkst_out_reg.
//
// Usage:
//   req channel: one transaction per event; req_tuser carries the operation
//   (press, release, query, focus loss), req_tdata the window id and key.
//   rsp channel: one result transaction per event, or one per held key for
//   a focus loss; rsp_tlast marks the final result of an event.
// Operation:
//   An event scans the window id table one entry per cycle, then the
//   window's key slots one per cycle, unless a focus loss stalls, through
//   the single read port of the slot RAM. The next request can be taken
//   in the cycle after the final result of an event is loaded. One event
//   is in work at a time and req_tready is high only between events.
//   Events with window id 0, or key 0 for anything but focus loss, skip
//   both scans and go straight to loading their result.
// Reset: clears the window count; RAM contents need no clearing, so the
//   block is ready in the first cycle after reset.
// Stall: a result waits in the output register; a focus loss pauses its
//   slot scan while the output register is full. A new event is accepted
//   while the last result of the previous one still waits.
`default_nettype none

module pressed_key_set_tracker #(
   parameter int SLOTS   = pkst_pkg::DEF_SLOTS,
   parameter int WINDOWS = pkst_pkg::DEF_WINDOWS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // window[31:0], key[39:32]
   input  wire logic [pkst_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // operation[1:0]
   input  wire logic [pkst_pkg::OP_W-1:0]           req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // key_held[0], released_key[8:1], released_valid[9], dropped[10],
   // no_window_room[11], zero[15:12]
   output logic      [pkst_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                                     rsp_tlast
);

   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int USED_W = $clog2(WINDOWS + 1);
   localparam int WIN_W  = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
   localparam int KDEPTH = WINDOWS * SLOTS;
   localparam int ADDR_W = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
   localparam int ID_W   = pkst_pkg::ID_W;
   localparam int KEY_W  = pkst_pkg::KEY_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WSCAN,
      ST_KSETUP,
      ST_KSCAN,
      ST_FINISH
   } state_type;

   state_type        state_ff, state_in;
   pkst_pkg::op_type op_ff, op_in;
   logic [ID_W-1:0]  id_ff, id_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic             skip_ff, skip_in;
   logic             full_ff, full_in;
   logic [USED_W-1:0] used_ff, used_in;
   logic [USED_W-1:0] widx_ff, widx_in;
   logic             wpv_ff, wpv_in;
   logic [WIN_W-1:0] wp_ff, wp_in;
   logic [WIN_W-1:0] w_ff, w_in;
   logic [CNT_W-1:0] counts_ff [WINDOWS];
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             kpv_ff, kpv_in;
   logic [CNT_W-1:0] pidx_ff, pidx_in;
   logic             free_ff, free_in;
   logic [CNT_W-1:0] free_idx_ff, free_idx_in;
   logic             dec_ff, dec_in;
   logic             held_ff, held_in;
   logic             pend_ff, pend_in;
   logic [KEY_W-1:0] pend_key_ff, pend_key_in;

   logic             cnt_we;
   logic [WIN_W-1:0] cnt_widx;
   logic [CNT_W-1:0] cnt_wdata;

   logic             wram_we;
   logic [WIN_W-1:0] wram_waddr;
   logic             wram_rd_en;
   logic [ID_W-1:0]  wram_rdata;

   logic             kram_we;
   logic [ADDR_W-1:0] kram_waddr;
   logic [KEY_W-1:0] kram_wdata;
   logic             kram_rd_en;
   logic [ADDR_W-1:0] kram_raddr;
   logic [KEY_W-1:0] kram_rdata;

   logic              out_load;
   logic              out_free;
   pkst_pkg::rsp_type out_data;
   logic              stall;

   assign req_tready = (state_ff == ST_IDLE);
   assign kram_raddr = base_ff + ADDR_W'(idx_ff);
   assign stall      = kpv_ff && (op_ff == pkst_pkg::OP_FOCUS) && (kram_rdata != '0)
                       && pend_ff && !out_free;

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      id_in       = id_ff;
      key_in      = key_ff;
      skip_in     = skip_ff;
      full_in     = full_ff;
      used_in     = used_ff;
      widx_in     = widx_ff;
      wpv_in      = wpv_ff;
      wp_in       = wp_ff;
      w_in        = w_ff;
      base_in     = base_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      kpv_in      = kpv_ff;
      pidx_in     = pidx_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      dec_in      = dec_ff;
      held_in     = held_ff;
      pend_in     = pend_ff;
      pend_key_in = pend_key_ff;
      cnt_we      = 1'b0;
      cnt_widx    = w_ff;
      cnt_wdata   = cnt_ff;
      wram_we     = 1'b0;
      wram_waddr  = used_ff[WIN_W-1:0];
      wram_rd_en  = 1'b0;
      kram_we     = 1'b0;
      kram_waddr  = base_ff + ADDR_W'(pidx_ff);
      kram_wdata  = '0;
      kram_rd_en  = 1'b0;
      out_load    = 1'b0;
      out_data    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in   = pkst_pkg::op_type'(req_tuser);
               id_in   = req_tdata[ID_W-1:0];
               key_in  = req_tdata[ID_W+KEY_W-1:ID_W];
               skip_in = (req_tdata[ID_W-1:0] == '0)
                         || ((pkst_pkg::op_type'(req_tuser) != pkst_pkg::OP_FOCUS)
                             && (req_tdata[ID_W+KEY_W-1:ID_W] == '0));
               full_in = 1'b0;
               widx_in = '0;
               wpv_in  = 1'b0;
               state_in = skip_in ? ST_FINISH : ST_WSCAN;
            end
         end
         ST_WSCAN: begin
            // issue the next id read while comparing the previous one
            if (widx_ff < used_ff) begin
               wram_rd_en = 1'b1;
               widx_in    = widx_ff + USED_W'(1);
               wpv_in     = 1'b1;
               wp_in      = widx_ff[WIN_W-1:0];
            end else begin
               wpv_in = 1'b0;
            end
            if (wpv_ff && (wram_rdata == id_ff)) begin
               w_in     = wp_ff;
               state_in = ST_KSETUP;
            end else if (!wpv_ff && (widx_ff >= used_ff)) begin
               if (used_ff == USED_W'(WINDOWS)) begin
                  full_in  = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  // claim a fresh entry
                  wram_we   = 1'b1;
                  cnt_we    = 1'b1;
                  cnt_widx  = used_ff[WIN_W-1:0];
                  cnt_wdata = '0;
                  used_in   = used_ff + USED_W'(1);
                  w_in      = used_ff[WIN_W-1:0];
                  state_in  = ST_KSETUP;
               end
            end
         end
         ST_KSETUP: begin
            base_in  = ADDR_W'(w_ff) * ADDR_W'(SLOTS);
            cnt_in   = counts_ff[w_ff];
            idx_in   = '0;
            kpv_in   = 1'b0;
            free_in  = 1'b0;
            dec_in   = 1'b0;
            held_in  = 1'b0;
            pend_in  = 1'b0;
            state_in = ST_KSCAN;
         end
         ST_KSCAN: begin
            if (!stall) begin
               if (idx_ff < cnt_ff) begin
                  kram_rd_en = 1'b1;
                  idx_in     = idx_ff + CNT_W'(1);
                  kpv_in     = 1'b1;
                  pidx_in    = idx_ff;
               end else begin
                  kpv_in = 1'b0;
               end
               if (!kpv_ff && (idx_ff >= cnt_ff)) begin
                  state_in = ST_FINISH;
               end
               if (kpv_ff) begin
                  case (op_ff)
                     pkst_pkg::OP_PRESS: begin
                        if (kram_rdata == key_ff) begin
                           // already held: stop and answer plainly
                           skip_in  = 1'b1;
                           state_in = ST_FINISH;
                        end else if (kram_rdata == '0) begin
                           free_in     = 1'b1;
                           free_idx_in = pidx_ff;
                        end
                     end
                     pkst_pkg::OP_RELEASE: begin
                        if (kram_rdata == key_ff) begin
                           kram_we = 1'b1;
                           if (CNT_W'(pidx_ff + CNT_W'(1)) == cnt_ff) begin
                              dec_in = 1'b1;
                           end
                        end
                     end
                     pkst_pkg::OP_QUERY: begin
                        if (kram_rdata == key_ff) begin
                           held_in = 1'b1;
                        end
                     end
                     pkst_pkg::OP_FOCUS: begin
                        // hold one key back so the final one can carry last
                        if (kram_rdata != '0) begin
                           if (pend_ff) begin
                              out_load                = 1'b1;
                              out_data.released_key   = pend_key_ff;
                              out_data.released_valid = 1'b1;
                           end
                           pend_in     = 1'b1;
                           pend_key_in = kram_rdata;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               out_load      = 1'b1;
               out_data.last = 1'b1;
               state_in      = ST_IDLE;
               if (full_ff) begin
                  out_data.no_window_room = 1'b1;
               end else if (!skip_ff) begin
                  case (op_ff)
                     pkst_pkg::OP_PRESS: begin
                        kram_wdata = key_ff;
                        if (free_ff) begin
                           kram_we    = 1'b1;
                           kram_waddr = base_ff + ADDR_W'(free_idx_ff);
                        end else if (cnt_ff < CNT_W'(SLOTS)) begin
                           kram_we    = 1'b1;
                           kram_waddr = base_ff + ADDR_W'(cnt_ff);
                           cnt_we     = 1'b1;
                           cnt_wdata  = cnt_ff + CNT_W'(1);
                        end else begin
                           out_data.dropped = 1'b1;
                        end
                     end
                     pkst_pkg::OP_RELEASE: begin
                        cnt_we    = 1'b1;
                        cnt_wdata = cnt_ff - CNT_W'(dec_ff);
                     end
                     pkst_pkg::OP_QUERY: begin
                        out_data.key_held = held_ff;
                     end
                     pkst_pkg::OP_FOCUS: begin
                        cnt_we                  = 1'b1;
                        cnt_wdata               = '0;
                        out_data.released_key   = pend_ff ? pend_key_ff : '0;
                        out_data.released_valid = pend_ff;
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         counts_ff[cnt_widx] <= cnt_wdata;
      end
      op_ff       <= op_in;
      id_ff       <= id_in;
      key_ff      <= key_in;
      skip_ff     <= skip_in;
      full_ff     <= full_in;
      widx_ff     <= widx_in;
      wp_ff       <= wp_in;
      w_ff        <= w_in;
      base_ff     <= base_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      pidx_ff     <= pidx_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      dec_ff      <= dec_in;
      held_ff     <= held_in;
      pend_key_ff <= pend_key_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         used_ff  <= '0;
         wpv_ff   <= 1'b0;
         kpv_ff   <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         wpv_ff   <= wpv_in;
         kpv_ff   <= kpv_in;
         pend_ff  <= pend_in;
      end
   end

   pkst_ram #(
      .WIDTH (ID_W),
      .DEPTH (WINDOWS)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (wram_we),
      .wr_addr (wram_waddr),
      .wr_data (id_ff),
      .rd_en   (wram_rd_en),
      .rd_addr (widx_ff[WIN_W-1:0]),
      .rd_data (wram_rdata)
   );

   pkst_ram #(
      .WIDTH (KEY_W),
      .DEPTH (KDEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (kram_we),
      .wr_addr (kram_waddr),
      .wr_data (kram_wdata),
      .rd_en   (kram_rd_en),
      .rd_addr (kram_raddr),
      .rd_data (kram_rdata)
   );

   pkst_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (out_load),
      .data       (out_data),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_W'(WINDOWS))
      else $error("window count beyond table size");

   a_slot_read_bound: assert property (@(posedge clock) disable iff (reset)
      kram_rd_en |-> (idx_ff < cnt_ff) && (cnt_ff <= CNT_W'(SLOTS)))
      else $error("slot read beyond count");

   a_no_write_on_stall: assert property (@(posedge clock) disable iff (reset)
      stall |-> !kram_we && !kram_rd_en && !out_load)
      else $error("slot scan advanced while stalled");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_tvalid)
      else $error("loaded result not presented");

endmodule

`default_nettype wire

@@ tb/pressed_key_set_tracker_test.sv @@
// Self-checking testbench of pressed_key_set_tracker: directed and random key events
// against a behavioral model of the per-window held-key sets. Needs pkst_pkg and the RTL.
`timescale 1ns / 100ps

module pressed_key_set_tracker_test;
   import pkst_pkg::*;

   localparam int SLOTS      = DEF_SLOTS;
   localparam int WINDOWS    = DEF_WINDOWS;
   localparam int QUIET_MAX  = 3000;
   localparam int TAIL_WAIT  = 100;
   localparam int HOLD_LEN   = 400;
   localparam int RAND_ITEMS = 140;

   typedef struct {
      op_type      op;
      logic [31:0] win_id;
      logic [7:0]  key;
   } key_evt_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [OP_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic rsp_tlast;

   pressed_key_set_tracker u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // model of the tracked key sets
   logic [31:0] win_ids [WINDOWS];
   int          win_used;
   logic [7:0]  held_slots [WINDOWS][SLOTS];
   int          slot_count [WINDOWS];

   key_evt_type pending_evt_q [$];
   rsp_type     expected_rsp_q [$];
   logic [31:0] win_pool [WINDOWS];

   int items_total;
   int items_accepted;
   int results_seen;
   int errors;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int draw_wait(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         calm_left = $urandom_range(5, 20);
         return 0;
      end
      return $urandom_range(0, 10);
   endfunction

   task automatic add_evt(input op_type op, input logic [31:0] id, input logic [7:0] key);
      key_evt_type e;
      e.op = op;
      e.win_id = id;
      e.key = key;
      pending_evt_q.push_back(e);
   endtask

   // Apply one event to the model and queue the results it must produce.
   task automatic track_event(input key_evt_type e);
      rsp_type r;
      rsp_type focus_q [$];
      int w, i, cnt, free_at;
      logic found;
      r = '0;
      r.last = 1'b1;
      w = -1;
      if (e.win_id == 0 || (e.op != OP_FOCUS && e.key == 0)) begin
         expected_rsp_q.push_back(r);
      end else begin
         for (i = 0; i < win_used; i++)
            if (w < 0 && win_ids[i] == e.win_id) w = i;
         if (w < 0 && win_used < WINDOWS) begin
            // claim the next free window entry
            w = win_used;
            win_ids[w] = e.win_id;
            slot_count[w] = 0;
            win_used++;
         end
         if (w < 0) begin
            r.no_window_room = 1'b1;
            expected_rsp_q.push_back(r);
         end else begin
            cnt = slot_count[w];
            case (e.op)
               OP_PRESS: begin
                  found = 1'b0;
                  free_at = -1;
                  for (i = 0; i < cnt; i++) begin
                     if (held_slots[w][i] == e.key) found = 1'b1;
                     if (!found && held_slots[w][i] == 0) free_at = i;
                  end
                  if (!found) begin
                     if (free_at >= 0) begin
                        held_slots[w][free_at] = e.key;
                     end else if (cnt < SLOTS) begin
                        held_slots[w][cnt] = e.key;
                        slot_count[w] = cnt + 1;
                     end else begin
                        r.dropped = 1'b1;
                     end
                  end
                  expected_rsp_q.push_back(r);
               end
               OP_RELEASE: begin
                  for (i = 0; i < cnt; i++) begin
                     if (held_slots[w][i] == e.key) begin
                        held_slots[w][i] = '0;
                        if (i == cnt - 1) cnt--;
                     end
                  end
                  slot_count[w] = cnt;
                  expected_rsp_q.push_back(r);
               end
               OP_QUERY: begin
                  for (i = 0; i < cnt; i++)
                     if (held_slots[w][i] == e.key) r.key_held = 1'b1;
                  expected_rsp_q.push_back(r);
               end
               default: begin
                  for (i = 0; i < cnt; i++) begin
                     if (held_slots[w][i] != 0) begin
                        r = '0;
                        r.released_key = held_slots[w][i];
                        r.released_valid = 1'b1;
                        focus_q.push_back(r);
                     end
                  end
                  slot_count[w] = 0;
                  if (focus_q.size() == 0) begin
                     r = '0;
                     r.last = 1'b1;
                     expected_rsp_q.push_back(r);
                  end else begin
                     focus_q[focus_q.size() - 1].last = 1'b1;
                     foreach (focus_q[k]) expected_rsp_q.push_back(focus_q[k]);
                  end
               end
            endcase
         end
      end
   endtask

   function automatic logic [7:0] pick_key();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 8'($urandom_range(1, 12));
      if (roll < 80) return ($urandom_range(0, 1) == 0) ? 8'hFF : 8'h80;
      if (roll < 95) return 8'($urandom_range(1, 255));
      return 8'h00;
   endfunction

   task automatic build_stimulus();
      int i, k, roll, counted;
      logic burst_done;
      op_type op;
      logic [31:0] id;
      logic [7:0] key;
      win_pool[0] = 32'hFFFF_FFFF;
      win_pool[1] = 32'h0000_0001;
      for (i = 2; i < WINDOWS; i++) begin
         win_pool[i] = $urandom;
         if (win_pool[i] == 0) win_pool[i] = 32'(i + 2);
      end

      // ignored events: key zero and window zero
      add_evt(OP_PRESS,   win_pool[0], 8'h00);
      add_evt(OP_FOCUS,   32'h0,       8'h00);
      add_evt(OP_PRESS,   32'h0,       8'h05);
      add_evt(OP_QUERY,   win_pool[0], 8'h00);
      add_evt(OP_RELEASE, win_pool[0], 8'h00);
      // focus loss claims the window with nothing held
      add_evt(OP_FOCUS,   win_pool[0], 8'h00);
      add_evt(OP_PRESS,   win_pool[0], 8'hFF);
      add_evt(OP_PRESS,   win_pool[0], 8'h01);
      add_evt(OP_PRESS,   win_pool[0], 8'hFF);
      add_evt(OP_QUERY,   win_pool[0], 8'hFF);
      add_evt(OP_QUERY,   win_pool[0], 8'h80);
      add_evt(OP_RELEASE, win_pool[0], 8'h80);
      // open a hole in slot 0, refill it, then release the last slot
      add_evt(OP_RELEASE, win_pool[0], 8'hFF);
      add_evt(OP_PRESS,   win_pool[0], 8'h80);
      add_evt(OP_RELEASE, win_pool[0], 8'h01);
      add_evt(OP_FOCUS,   win_pool[0], 8'hAA);
      for (i = 1; i < WINDOWS; i++)
         add_evt(OP_PRESS, win_pool[i], 8'(8'h55 + i));
      // every entry is claimed now
      add_evt(OP_PRESS,   32'h8000_0000, 8'h03);
      add_evt(OP_FOCUS,   win_pool[1], 8'h00);

      counted = 0;
      burst_done = 1'b0;
      while (counted < RAND_ITEMS) begin
         if (!burst_done && counted >= 60) begin
            // fill one window past its slot limit, then flush it
            burst_done = 1'b1;
            for (k = 1; k <= SLOTS + 6; k++)
               add_evt(OP_PRESS, win_pool[2], 8'(k));
            add_evt(OP_QUERY, win_pool[2], 8'(SLOTS + 6));
            add_evt(OP_FOCUS, win_pool[2], 8'h00);
            counted += SLOTS + 8;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 40)      op = OP_PRESS;
            else if (roll < 65) op = OP_RELEASE;
            else if (roll < 88) op = OP_QUERY;
            else                op = OP_FOCUS;
            roll = $urandom_range(0, 99);
            if (roll < 88)      id = win_pool[$urandom_range(0, WINDOWS - 1)];
            else if (roll < 94) id = $urandom;
            else                id = 32'h0;
            key = (op == OP_FOCUS) ? 8'($urandom) : pick_key();
            add_evt(op, id, key);
            if (id != 0 && (op == OP_FOCUS || key != 0)) counted++;
         end
      end
      items_total = pending_evt_q.size();
   endtask

   // request driver
   key_evt_type cur_evt;
   logic        offering = 1'b0;
   int          req_gap = 0;
   int          req_calm = 0;

   always @(posedge clock) begin
      if (reset) begin
         offering = 1'b0;
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tuser <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            track_event(cur_evt);
            items_accepted++;
            offering = 1'b0;
            req_gap = draw_wait(req_calm);
         end
         if (!offering) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_evt_q.size() > 0) begin
               cur_evt = pending_evt_q.pop_front();
               offering = 1'b1;
            end
         end
         req_tvalid <= offering;
         req_tdata <= {cur_evt.key, cur_evt.win_id};
         req_tuser <= cur_evt.op;
      end
   end

   task automatic compare_field(input string name, input int expv, input int actv);
      if (expv != actv) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, expv, actv);
         errors++;
      end
   endtask

   // response monitor
   int   rsp_stall = 0;
   int   rsp_calm = 0;
   int   hold_left = 0;
   logic hold_done = 1'b0;

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_rsp_q.size() == 0) begin
               $error("result transaction with no pending expectation: tdata 0x%0h",
                      rsp_tdata);
               errors++;
            end else begin
               exp_rsp = expected_rsp_q.pop_front();
               compare_field("key_held", exp_rsp.key_held, rsp_tdata[0]);
               compare_field("released_key", exp_rsp.released_key, rsp_tdata[8:1]);
               compare_field("released_valid", exp_rsp.released_valid, rsp_tdata[9]);
               compare_field("dropped", exp_rsp.dropped, rsp_tdata[10]);
               compare_field("no_window_room", exp_rsp.no_window_room, rsp_tdata[11]);
               compare_field("pad", 0, rsp_tdata[15:12]);
               compare_field("last", exp_rsp.last, rsp_tlast);
            end
            rsp_stall = draw_wait(rsp_calm);
         end
         // hold off once for a long stretch so the block backs up
         if (!hold_done && results_seen >= 30) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog: no transaction on either side for too long
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_MAX) begin
         $display("pressed_key_set_tracker_test: done, errors");
         $finish;
      end
   end

   initial begin
      items_accepted = 0;
      results_seen = 0;
      errors = 0;
      win_used = 0;
      build_stimulus();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      while (items_accepted < items_total || expected_rsp_q.size() != 0)
         @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);
      if (errors == 0 && expected_rsp_q.size() == 0) begin
         $display("pressed_key_set_tracker_test: done, clean");
      end else begin
         $display("pressed_key_set_tracker_test: done, errors");
      end
      $finish;
   end

endmodule
